// ----- rtl/core/rnsc_pkg.sv -----
// rnsc_pkg: shared types and character codes for the real number syntax checker
// no dependencies
`timescale 1ns / 1ps

package rnsc_pkg;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_EXP_U = 8'h45;
  localparam logic [7:0] CHAR_EXP_L = 8'h65;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef struct packed {
    logic digit_seen;
    logic trailing_space_seen;
    logic dot_seen;
    logic exponent_seen;
    logic mantissa_started;
    logic exponent_started;
    logic rejected;
  } rnsc_flags_t;

endpackage

// ----- rtl/core/real_number_syntax_checker.sv -----
// real_number_syntax_checker: streaming scanner that checks decimal real literal syntax
// depends on rnsc_pkg
`timescale 1ns / 1ps

// One character is taken per transfer, one per cycle with no bubbles while the result
// side is not stalled. Ordinary characters only update the scan flags and give no result;
// a zero character ends the string, and in the cycle after it is taken is_real shows
// the verdict (1 when the string is a valid real literal) while the flags clear for the
// next string. The result sits in a one-entry output register; char_stall goes high
// only while that register holds a result that the consumer is stalling.
module real_number_syntax_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] character,
  output logic       real_valid,
  input  logic       real_stall,
  output logic       is_real
);

  rnsc_pkg::rnsc_flags_t flags;
  rnsc_pkg::rnsc_flags_t flags_next;
  rnsc_pkg::rnsc_flags_t scan;

  logic accept;
  logic term;
  logic blank;
  logic digit;
  logic sign;
  logic expo;
  logic verdict;

  assign char_stall = real_valid && real_stall;
  assign accept     = char_valid && !char_stall;
  assign term       = (character == rnsc_pkg::CHAR_NUL);
  assign verdict    = !flags.rejected && flags.digit_seen;

  always_comb begin
    blank = character inside {rnsc_pkg::CHAR_SPACE,
                              [rnsc_pkg::CHAR_TAB:rnsc_pkg::CHAR_CR]};
    digit = character inside {[rnsc_pkg::CHAR_ZERO:rnsc_pkg::CHAR_NINE]};
    sign  = character inside {rnsc_pkg::CHAR_PLUS, rnsc_pkg::CHAR_MINUS};
    expo  = character inside {rnsc_pkg::CHAR_EXP_U, rnsc_pkg::CHAR_EXP_L};
  end

  // per-character flag update, first matching rule wins
  always_comb begin
    scan = flags;
    if (!flags.rejected) begin
      if (blank) begin
        if (flags.digit_seen || flags.mantissa_started) scan.trailing_space_seen = 1'b1;
      end else if (digit) begin
        if (flags.trailing_space_seen) begin
          scan.rejected = 1'b1;
        end else begin
          scan.digit_seen       = 1'b1;
          scan.mantissa_started = 1'b1;
          if (flags.exponent_seen) scan.exponent_started = 1'b1;
        end
      end else if (flags.trailing_space_seen) begin
        scan.rejected = 1'b1;
      end else if (sign && !flags.digit_seen && !flags.dot_seen && !flags.mantissa_started) begin
        scan.mantissa_started = 1'b1;
      end else if (character == rnsc_pkg::CHAR_DOT && !flags.dot_seen) begin
        // also taken after the exponent letter
        scan.dot_seen = 1'b1;
      end else if (expo && !flags.exponent_seen && flags.digit_seen) begin
        scan.exponent_seen = 1'b1;
        scan.digit_seen    = 1'b0;
      end else if (sign && flags.exponent_seen && !flags.exponent_started) begin
        scan.exponent_started = 1'b1;
      end else begin
        scan.rejected = 1'b1;
      end
    end
  end

  always_comb begin
    flags_next = flags;
    if (accept) begin
      if (term) flags_next = '0;
      else      flags_next = scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      real_valid <= 1'b0;
    end else if (accept && term) begin
      real_valid <= 1'b1;
    end else if (!real_stall) begin
      real_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && term) is_real <= verdict;
  end

  // a new result only comes from an accepted terminator
  a_result_from_term: assert property (@(posedge clk) disable iff (rst)
    $rose(real_valid) |-> $past(accept && term))
    else $error("result without terminator transfer");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    accept && term |=> real_valid && (is_real == $past(verdict)))
    else $error("verdict mismatch");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && term |=> flags == '0)
    else $error("flags not cleared after terminator");

  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.rejected && !(accept && term) |=> flags.rejected)
    else $error("reject flag dropped inside a string");

endmodule

// ----- test/real_number_syntax_checker_tb.sv -----
// real_number_syntax_checker_tb: streams strings one character at a time into the checker and
// compares every is_real verdict with a flag-level prediction; depends on rnsc_pkg and the RTL
`timescale 1ns / 1ps

module real_number_syntax_checker_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int CHAR_COUNT  = 650;

  // tracks the scan flags of the string in flight and the verdicts still owed
  class verdict_board;
    rnsc_pkg::rnsc_flags_t flags;
    bit                    verdict_q[$];
    int                    errors;

    function new();
      flags  = '0;
      errors = 0;
    endfunction

    function void take_char(logic [7:0] c);
      bit blank;
      bit digit;
      bit sign;
      bit expo;
      blank = c inside {rnsc_pkg::CHAR_SPACE, [rnsc_pkg::CHAR_TAB:rnsc_pkg::CHAR_CR]};
      digit = c inside {[rnsc_pkg::CHAR_ZERO:rnsc_pkg::CHAR_NINE]};
      sign  = c inside {rnsc_pkg::CHAR_PLUS, rnsc_pkg::CHAR_MINUS};
      expo  = c inside {rnsc_pkg::CHAR_EXP_U, rnsc_pkg::CHAR_EXP_L};
      if (c == rnsc_pkg::CHAR_NUL) begin
        verdict_q.push_back(!flags.rejected && flags.digit_seen);
        flags = '0;
      end else if (!flags.rejected) begin
        if (blank) begin
          if (flags.digit_seen || flags.mantissa_started) flags.trailing_space_seen = 1'b1;
        end else if (digit) begin
          if (flags.trailing_space_seen) begin
            flags.rejected = 1'b1;
          end else begin
            flags.digit_seen       = 1'b1;
            flags.mantissa_started = 1'b1;
            if (flags.exponent_seen) flags.exponent_started = 1'b1;
          end
        end else if (flags.trailing_space_seen) begin
          flags.rejected = 1'b1;
        end else if (sign && !flags.digit_seen && !flags.dot_seen && !flags.mantissa_started) begin
          flags.mantissa_started = 1'b1;
        end else if (c == rnsc_pkg::CHAR_DOT && !flags.dot_seen) begin
          // a dot is still taken after the exponent letter
          flags.dot_seen = 1'b1;
        end else if (expo && !flags.exponent_seen && flags.digit_seen) begin
          flags.exponent_seen = 1'b1;
          flags.digit_seen    = 1'b0;
        end else if (sign && flags.exponent_seen && !flags.exponent_started) begin
          flags.exponent_started = 1'b1;
        end else begin
          flags.rejected = 1'b1;
        end
      end
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: is_real %b with no verdict expected", $time, got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("%0t: is_real mismatch, expected %b, got %b", $time, want, got);
        end
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] character  = rnsc_pkg::CHAR_NUL;
  logic       real_valid;
  logic       real_stall = 1'b0;
  logic       is_real;

  verdict_board board = new();
  logic [7:0]   text_q[$];
  bit           calm       = 1'b0;
  int           sent       = 0;
  int           stall_left = 0;
  int           quiet      = 0;

  real_number_syntax_checker u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .real_valid (real_valid),
    .real_stall (real_stall),
    .is_real    (is_real)
  );

  always #6 clk = ~clk;

  // result side: check each transfer, stall in random bursts
  always @(posedge clk) begin
    if (real_valid && !real_stall) board.check_verdict(is_real);
    if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 11);
    real_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (real_valid && !real_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? rnsc_pkg::CHAR_SPACE : rnsc_pkg::CHAR_TAB + 8'(r - 1);
  endfunction

  function automatic logic [7:0] rand_digit();
    return rnsc_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? rnsc_pkg::CHAR_PLUS : rnsc_pkg::CHAR_MINUS;
  endfunction

  task automatic send_char(logic [7:0] c);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    repeat (gap) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    character  <= c;
    forever begin
      @(posedge clk);
      if (char_valid && !char_stall) break;
    end
    board.take_char(c);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(rnsc_pkg::CHAR_NUL);
    text_q.delete();
  endtask

  task automatic send_word(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // blanks, sign, digits, dot, exponent and blanks, each part optional
  task automatic make_literal();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) text_q.push_back(rand_blank());
    if ($urandom_range(0, 2) == 0) text_q.push_back(rand_sign());
    n = $urandom_range(0, 3);
    repeat (n) text_q.push_back(rand_digit());
    if ($urandom_range(0, 1)) begin
      text_q.push_back(rnsc_pkg::CHAR_DOT);
      n = $urandom_range(0, 3);
      repeat (n) text_q.push_back(rand_digit());
    end
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back($urandom_range(0, 1) ? rnsc_pkg::CHAR_EXP_U : rnsc_pkg::CHAR_EXP_L);
      if ($urandom_range(0, 1)) text_q.push_back(rand_sign());
      n = $urandom_range(0, 2);
      repeat (n) text_q.push_back(rand_digit());
    end
    n = $urandom_range(0, 2);
    repeat (n) text_q.push_back(rand_blank());
  endtask

  task automatic mutate_text();
    int         pos;
    logic [7:0] b;
    pos = $urandom_range(0, text_q.size());
    case ($urandom_range(0, 5))
      0:       b = rand_sign();
      1:       b = rnsc_pkg::CHAR_DOT;
      2:       b = $urandom_range(0, 1) ? rnsc_pkg::CHAR_EXP_U : rnsc_pkg::CHAR_EXP_L;
      3:       b = rand_digit();
      4:       b = rand_blank();
      default: b = 8'($urandom_range(1, 255));
    endcase
    if (pos == text_q.size() || $urandom_range(0, 1)) text_q.insert(pos, b);
    else text_q[pos] = b;
  endtask

  task automatic make_noise();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
  endtask

  initial begin
    int r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word("");
    text_q = '{rnsc_pkg::CHAR_TAB, rnsc_pkg::CHAR_PLUS, 8'h31, rnsc_pkg::CHAR_DOT,
               rnsc_pkg::CHAR_EXP_L, rnsc_pkg::CHAR_MINUS, 8'h39,
               rnsc_pkg::CHAR_SPACE, rnsc_pkg::CHAR_CR};
    send_text();
    send_word("5E.2");
    send_word("1 2");
    text_q = '{8'hFF, 8'h80};
    send_text();

    while (sent < CHAR_COUNT) begin
      if (sent > CHAR_COUNT - 100) calm = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 3) begin
        make_noise();
      end else begin
        make_literal();
        if (r < 9) mutate_text();
      end
      send_text();
    end
    char_valid <= 1'b0;

    while (board.verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
